[rtl/bcr_pkg.sv]
// ----------------------------------------------------------------------------
// bcr_pkg
// Shared types and constants for the auto-repeat button controller: event
// codes, register indexes, repeat modes and the controller/datapath structs.
// ----------------------------------------------------------------------------
package bcr_pkg;

    // Default number of fraction bits of the repeat period.
    localparam int FRAC_BITS_DEF = 16;

    // Field widths.
    localparam int FUNC_W   = 3;
    localparam int MS_W     = 16;
    localparam int TL_W     = 18;
    localparam int CFG_AW   = 3;
    localparam int CFG_DW   = 16;
    localparam int TDATA_IW = 16;
    localparam int TUSER_IW = 4;
    localparam int TDATA_OW = 8;

    // Register reset values.
    localparam logic [MS_W-1:0] DELAY_RST   = 16'd500;
    localparam logic [MS_W-1:0] INITIAL_RST = 16'd200;
    localparam logic [MS_W-1:0] MINIMUM_RST = 16'd50;
    localparam logic [MS_W-1:0] ACCEL_RST   = 16'd2000;

    // Register indexes on the configuration port.
    typedef enum logic [CFG_AW-1:0] {
        REG_ENABLE  = 3'd0,
        REG_DELAY   = 3'd1,
        REG_INITIAL = 3'd2,
        REG_MINIMUM = 3'd3,
        REG_ACCEL   = 3'd4
    } t_reg_idx;

    // Event codes.
    typedef enum logic [FUNC_W-1:0] {
        FN_TICK       = 3'd0,
        FN_MOUSE_DOWN = 3'd1,
        FN_MOUSE_UP   = 3'd2,
        FN_MOUSE_CLK  = 3'd3,
        FN_SPACE_DOWN = 3'd4,
        FN_SPACE_UP   = 3'd5,
        FN_ENTER_DOWN = 3'd6,
        FN_OTHER_KEY  = 3'd7
    } t_func;

    // Repeat modes.
    typedef enum logic [1:0] {
        MODE_DISABLED  = 2'd0,
        MODE_STANDBY   = 2'd1,
        MODE_DELAY     = 2'd2,
        MODE_REPEATING = 2'd3
    } t_mode;

    // One result item; press sits in the lowest bit.
    typedef struct packed {
        logic key_handled;
        logic focus_request;
        logic down_clear;
        logic down_set;
        logic release_pulse;
        logic click_pulse;
        logic press_pulse;
    } t_res;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;       // input transaction accepted
        logic evt;        // apply the event
        logic mul;        // register the diff * delta product
        logic div_start;  // launch the divider
        logic add;        // accumulate and saturate the period
        logic fire;       // countdown compare and repeat decision
        logic tl;         // countdown from the period integer part
        logic push;       // move the result to the output register
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic tick_go;    // tick event with an active countdown
        logic div_done;   // divider quotient ready
        logic fire_rep;   // repeat fires while already repeating
        logic out_free;   // output register can take a result
    } t_stat;

endpackage

[rtl/button_click_repeat_controller.sv]
// A non-tick event or idle tick is applied and moved to the output register;
// an active tick also runs the multiplier, bit-serial divider, period update and
// repeat decision, and reloads the countdown if a repeat fires while repeating.
// Throughput: one event at a time; the next is accepted once the result has
// moved to the output register, even while that result waits to be taken.
// Reset: synchronous, active low; repeat disabled, countdown idle, period 0.
// ----------------------------------------------------------------------------
// button_click_repeat_controller
// Accelerating auto-repeat button: turns mouse, key and tick events into
// press, click, release, down-indicator, focus and key-handled pulses.
// ----------------------------------------------------------------------------
module button_click_repeat_controller import bcr_pkg::*; #(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    input  logic [TDATA_IW-1:0] s_axis_tdata,   // [15:0] delta_ms
    input  logic [TUSER_IW-1:0] s_axis_tuser,   // [2:0] func, [3] key_modified
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    output logic [TDATA_OW-1:0] m_axis_tdata,   // [0] press_pulse, [1] click_pulse,
                                                // [2] release_pulse, [3] down_set,
                                                // [4] down_clear, [5] focus_request,
                                                // [6] key_handled, [7] zero
    input  logic                i_cfg_we,
    input  logic [CFG_AW-1:0]   i_cfg_addr,
    input  logic [CFG_DW-1:0]   i_cfg_wdata
);

    t_cmd  w_cmd;
    t_stat w_stat;
    t_res  w_res;

    bcr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_axis_tvalid),
        .o_s_tready (s_axis_tready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    bcr_datapath #(
        .FRAC_BITS (FRAC_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat),
        .i_tdata     (s_axis_tdata),
        .i_tuser     (s_axis_tuser),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .i_m_tready  (m_axis_tready),
        .o_m_tvalid  (m_axis_tvalid),
        .o_m_res     (w_res)
    );

    // Pack the result flags, press in the lowest bit.
    assign m_axis_tdata = {1'b0, w_res};

endmodule

[rtl/bcr_div.sv]
// ----------------------------------------------------------------------------
// bcr_div
// Restoring unsigned divider, one quotient bit per cycle. The quotient stays
// valid from the done pulse until the next start.
// ----------------------------------------------------------------------------
module bcr_div import bcr_pkg::*; #(
    parameter int NW = 2 * MS_W + FRAC_BITS_DEF,
    parameter int DW = MS_W
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [NW-1:0] i_dividend,
    input  logic [DW-1:0] i_divisor,
    output logic [NW-1:0] o_quot,
    output logic          o_done
);

    localparam int CW = $clog2(NW + 1);

    logic [NW-1:0] r_q;
    logic [DW-1:0] r_r;
    logic [DW-1:0] r_d;
    logic [CW-1:0] r_cnt;
    logic          r_busy;
    logic          r_done;

    logic [DW:0]   w_sh;
    logic [DW:0]   w_sub;
    logic          w_ge;

    // Shift in the next dividend bit and trial-subtract the divisor.
    always_comb begin
        w_sh  = {r_r, r_q[NW-1]};
        w_ge  = (w_sh >= {1'b0, r_d});
        w_sub = w_sh - {1'b0, r_d};
    end

    // Control: busy flag, bit counter and done pulse.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(NW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CW'(1);
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath: partial remainder and quotient shift register.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q <= i_dividend;
            r_r <= '0;
            r_d <= i_divisor;
        end else if (r_busy) begin
            r_q <= {r_q[NW-2:0], w_ge};
            r_r <= w_ge ? w_sub[DW-1:0] : w_sh[DW-1:0];
        end
    end

    assign o_quot = r_q;
    assign o_done = r_done;

endmodule

[rtl/bcr_datapath.sv]
// ----------------------------------------------------------------------------
// bcr_datapath
// Configuration registers, button state, repeat countdown and period
// arithmetic, pending result and output register.
// ----------------------------------------------------------------------------
module bcr_datapath import bcr_pkg::*; #(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_cmd                i_cmd,
    output t_stat               o_stat,
    input  logic [TDATA_IW-1:0] i_tdata,
    input  logic [TUSER_IW-1:0] i_tuser,
    input  logic                i_cfg_we,
    input  logic [CFG_AW-1:0]   i_cfg_addr,
    input  logic [CFG_DW-1:0]   i_cfg_wdata,
    input  logic                i_m_tready,
    output logic                o_m_tvalid,
    output t_res                o_m_res
);

    localparam int PW = FRAC_BITS + TL_W;      // period width
    localparam int PRW = 2 * MS_W;             // product width
    localparam int NW = PRW + FRAC_BITS;       // dividend / quotient width
    localparam int SW = NW + 2;                // accumulate width

    localparam logic signed [SW-1:0] PMAX = {{(SW-PW+1){1'b0}}, {(PW-1){1'b1}}};
    localparam logic signed [SW-1:0] PMIN = {{(SW-PW+1){1'b1}}, {(PW-1){1'b0}}};
    localparam logic signed [TL_W-1:0] IDLE_LEFT = '1;

    // Configuration registers.
    logic [MS_W-1:0] r_delay, r_initial, r_minimum, r_accel;

    // Button state.
    t_mode                  r_mode, n_mode;
    logic signed [TL_W-1:0] r_tl, n_tl;
    logic signed [PW-1:0]   r_period, n_period;
    logic                   r_mouse, n_mouse;
    logic                   r_space, n_space;

    // Latched input item and working registers.
    t_func                  r_func;
    logic [MS_W-1:0]        r_delta;
    logic                   r_mod;
    logic [PRW-1:0]         r_prod;
    logic                   r_diff_neg, r_diff_pos;
    t_res                   r_res, n_res;
    logic                   r_out_valid;
    t_res                   r_out;

    logic [NW-1:0]          w_quot;
    logic                   w_div_done;
    logic [MS_W-1:0]        w_mag_diff;
    logic [MS_W-1:0]        w_divisor;
    logic                   w_active;
    logic                   w_fire;
    logic signed [SW-1:0]   w_step;
    logic signed [SW-1:0]   w_sum;
    logic signed [PW-1:0]   w_sat;
    logic signed [PW-1:0]   w_fin;
    logic signed [PW-1:0]   w_init_fx;
    logic signed [PW-1:0]   w_padj;
    logic signed [PW-1:0]   w_ipart;
    logic                   w_clamp;
    logic                   w_ignored;

    // Configuration registers other than the enable.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_delay   <= DELAY_RST;
            r_initial <= INITIAL_RST;
            r_minimum <= MINIMUM_RST;
            r_accel   <= ACCEL_RST;
        end else if (i_cfg_we) begin
            unique case (t_reg_idx'(i_cfg_addr))
                REG_DELAY:   r_delay   <= i_cfg_wdata;
                REG_INITIAL: r_initial <= i_cfg_wdata;
                REG_MINIMUM: r_minimum <= i_cfg_wdata;
                REG_ACCEL:   r_accel   <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // Magnitude of the period difference and the divisor.
    always_comb begin
        w_mag_diff = (r_minimum < r_initial) ? (r_initial - r_minimum)
                                             : (r_minimum - r_initial);
        w_divisor  = (r_accel == '0) ? MS_W'(1) : r_accel;
    end

    bcr_div #(
        .NW (NW),
        .DW (MS_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend ({r_prod, {FRAC_BITS{1'b0}}}),
        .i_divisor  (w_divisor),
        .o_quot     (w_quot),
        .o_done     (w_div_done)
    );

    // Period accumulation with saturation, clamp and integer part.
    always_comb begin
        w_step    = r_diff_neg ? -$signed({2'b00, w_quot}) : $signed({2'b00, w_quot});
        w_sum     = {{(SW-PW){r_period[PW-1]}}, r_period} + w_step;
        if (w_sum > PMAX) begin
            w_sat = PW'(PMAX);
        end else if (w_sum < PMIN) begin
            w_sat = PW'(PMIN);
        end else begin
            w_sat = w_sum[PW-1:0];
        end
        w_fin     = {{(PW-MS_W-FRAC_BITS){1'b0}}, r_minimum, {FRAC_BITS{1'b0}}};
        w_init_fx = {{(PW-MS_W-FRAC_BITS){1'b0}}, r_initial, {FRAC_BITS{1'b0}}};
        w_clamp   = r_diff_pos ? (r_period >= w_fin) : (r_period <= w_fin);
        w_padj    = r_period + (r_period[PW-1] ? {{(PW-FRAC_BITS){1'b0}},
                                                  {FRAC_BITS{1'b1}}} : '0);
        w_ipart   = w_padj >>> FRAC_BITS;
    end

    // Countdown state and event decode.
    always_comb begin
        w_active  = ((r_mode == MODE_DELAY) || (r_mode == MODE_REPEATING)) &&
                    (r_tl != IDLE_LEFT);
        w_fire    = $signed({r_tl[TL_W-1], r_tl}) < $signed({3'b000, r_delta});
        w_ignored = r_mod && (r_func >= FN_SPACE_DOWN);
    end

    // Next state of the button, countdown and period.
    always_comb begin
        n_mode   = r_mode;
        n_tl     = r_tl;
        n_period = r_period;
        n_mouse  = r_mouse;
        n_space  = r_space;
        n_res    = r_res;

        if (i_cfg_we && (t_reg_idx'(i_cfg_addr) == REG_ENABLE)) begin
            if (i_cfg_wdata[0]) begin
                n_mode = MODE_STANDBY;
            end else begin
                n_mode = MODE_DISABLED;
                n_tl   = IDLE_LEFT;
            end
        end

        if (i_cmd.evt) begin
            n_res = '0;
            if (!w_ignored) begin
                unique case (r_func)
                    FN_TICK: ;
                    FN_MOUSE_DOWN: begin
                        n_res.focus_request = 1'b1;
                        n_res.press_pulse   = 1'b1;
                        n_mouse             = 1'b1;
                        if (r_mode == MODE_STANDBY) begin
                            n_mode = MODE_DELAY;
                            n_tl   = TL_W'(r_delay);
                        end
                    end
                    FN_MOUSE_UP: begin
                        if (r_space) begin
                            n_res.down_set = 1'b1;
                        end else begin
                            n_res.release_pulse = 1'b1;
                        end
                        n_mouse = 1'b0;
                        if (r_mode != MODE_DISABLED) begin
                            n_mode = MODE_STANDBY;
                            n_tl   = IDLE_LEFT;
                        end
                    end
                    FN_MOUSE_CLK: begin
                        n_res.click_pulse = 1'b1;
                    end
                    FN_SPACE_DOWN: begin
                        n_space             = 1'b1;
                        n_res.down_set      = 1'b1;
                        n_res.press_pulse   = 1'b1;
                        n_res.key_handled   = 1'b1;
                        if (r_mode == MODE_STANDBY) begin
                            n_mode = MODE_DELAY;
                            n_tl   = TL_W'(r_delay);
                        end
                    end
                    FN_SPACE_UP: begin
                        if (r_space) begin
                            n_space           = 1'b0;
                            n_res.key_handled = 1'b1;
                            if (!r_mouse) begin
                                n_res.down_clear    = 1'b1;
                                n_res.click_pulse   = 1'b1;
                                n_res.release_pulse = 1'b1;
                                if (r_mode != MODE_DISABLED) begin
                                    n_mode = MODE_STANDBY;
                                    n_tl   = IDLE_LEFT;
                                end
                            end
                        end
                    end
                    FN_ENTER_DOWN: begin
                        n_res.press_pulse   = 1'b1;
                        n_res.click_pulse   = 1'b1;
                        n_res.release_pulse = 1'b1;
                        n_res.key_handled   = 1'b1;
                    end
                    FN_OTHER_KEY: ;
                    default: ;
                endcase
            end
        end

        if (i_cmd.add) begin
            n_period = w_sat;
        end

        if (i_cmd.fire) begin
            if (w_fire) begin
                n_res.click_pulse = 1'b1;
                if (r_mode == MODE_DELAY) begin
                    n_mode   = MODE_REPEATING;
                    n_period = w_init_fx;
                    n_tl     = TL_W'(r_initial);
                end else if (w_clamp) begin
                    n_period = w_fin;
                end
            end else begin
                n_tl = r_tl - TL_W'(r_delta);
            end
        end

        if (i_cmd.tl) begin
            n_tl = w_ipart[TL_W-1:0];
        end
    end

    // State registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= MODE_DISABLED;
            r_tl     <= IDLE_LEFT;
            r_period <= '0;
            r_mouse  <= 1'b0;
            r_space  <= 1'b0;
        end else begin
            r_mode   <= n_mode;
            r_tl     <= n_tl;
            r_period <= n_period;
            r_mouse  <= n_mouse;
            r_space  <= n_space;
        end
    end

    // Input latch, product and pending result.
    always_ff @(posedge i_clk) begin
        r_res <= n_res;
        if (i_cmd.load) begin
            r_func  <= t_func'(i_tuser[FUNC_W-1:0]);
            r_mod   <= i_tuser[FUNC_W];
            r_delta <= i_tdata[MS_W-1:0];
        end
        if (i_cmd.mul) begin
            r_prod     <= w_mag_diff * r_delta;
            r_diff_neg <= (r_minimum < r_initial);
            r_diff_pos <= (r_minimum > r_initial);
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.push) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            r_out <= r_res;
        end
    end

    // Status to the controller.
    always_comb begin
        o_stat.tick_go  = (r_func == FN_TICK) && w_active;
        o_stat.div_done = w_div_done;
        o_stat.fire_rep = w_fire && (r_mode == MODE_REPEATING);
        o_stat.out_free = !r_out_valid || i_m_tready;
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_res    = r_out;

endmodule

[rtl/bcr_ctrl.sv]
// ----------------------------------------------------------------------------
// bcr_ctrl
// Sequencer for one event: accept, apply, optional tick arithmetic through
// the multiplier and divider, then hand the result to the output register.
// ----------------------------------------------------------------------------
module bcr_ctrl import bcr_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_s_tvalid,
    output logic  o_s_tready,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    typedef enum logic [8:0] {
        S_IDLE   = 9'b000000001,
        S_EVT    = 9'b000000010,
        S_MUL    = 9'b000000100,
        S_DSTART = 9'b000001000,
        S_DIV    = 9'b000010000,
        S_ADD    = 9'b000100000,
        S_FIRE   = 9'b001000000,
        S_TL     = 9'b010000000,
        S_PUSH   = 9'b100000000
    } t_state;

    t_state r_state, n_state;

    // Next state and commands.
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                o_cmd.load = i_s_tvalid;
                if (i_s_tvalid) begin
                    n_state = S_EVT;
                end
            end
            S_EVT: begin
                o_cmd.evt = 1'b1;
                n_state   = i_stat.tick_go ? S_MUL : S_PUSH;
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_DSTART;
            end
            S_DSTART: begin
                o_cmd.div_start = 1'b1;
                n_state         = S_DIV;
            end
            S_DIV: begin
                if (i_stat.div_done) begin
                    n_state = S_ADD;
                end
            end
            S_ADD: begin
                o_cmd.add = 1'b1;
                n_state   = S_FIRE;
            end
            S_FIRE: begin
                o_cmd.fire = 1'b1;
                n_state    = i_stat.fire_rep ? S_TL : S_PUSH;
            end
            S_TL: begin
                o_cmd.tl = 1'b1;
                n_state  = S_PUSH;
            end
            S_PUSH: begin
                o_cmd.push = i_stat.out_free;
                if (i_stat.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_s_tready = (r_state == S_IDLE);

endmodule
